FILE: hdl/dis_pkg.sv
// shared constants, status codes and control types for the dedup id set block
// no dependencies; used by dis_valid, dis_scan and dedup_id_set_insert

package dis_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic                done;
        logic                insert;
        logic [STATUS_W-1:0] status;
    } res_ctl_t;

endpackage

FILE: hdl/dis_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module dis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/dis_valid.sv
// entry counts of both groups, cleared at reset; a slot is valid below its group's count
// depends on dis_pkg

module dis_valid #(
    parameter int DEPTH = dis_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       lk_grp,
    input  logic [$clog2(DEPTH)-1:0]   lk_idx,
    output logic                       lk_valid,
    input  logic                       set_en,
    input  logic                       set_grp,
    input  logic [$clog2(DEPTH)-1:0]   set_idx,
    input  logic                       cnt_grp,
    output logic [$clog2(DEPTH+1)-1:0] cnt
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
        end
        else if (set_en)
        begin
            cnt_reg[set_grp] <= cnt_reg[set_grp] + CNT_W'(1);
        end
    end

    // inserts fill from slot 0 and nothing is freed, so valid slots sit below the count
    assign lk_valid = (CNT_W'(lk_idx) < cnt_reg[lk_grp]);
    assign cnt      = cnt_reg[cnt_grp];

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        set_en |-> cnt_reg[set_grp] < CNT_W'(DEPTH))
        else $error("insert into a full group");

    a_fill_point: assert property (@(posedge clk) disable iff (!rst_n)
        set_en |-> CNT_W'(set_idx) == cnt_reg[set_grp])
        else $error("insert away from the fill point");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        set_en |=> cnt_reg[$past(set_grp)] == $past(cnt_reg[set_grp]) + CNT_W'(1))
        else $error("group count did not advance on insert");

endmodule

FILE: hdl/dis_scan.sv
// scan sequencer: reads the id ram slot by slot, looks for a match and the first free slot
// depends on dis_pkg; drives the id ram ports and the valid-bit lookup

module dis_scan #(
    parameter int DEPTH = dis_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [dis_pkg::ID_W-1:0]          item_id,
    input  logic                              group,
    output logic                              busy,
    output logic                              rd_en,
    output logic [$clog2(DEPTH):0]            rd_addr,
    input  logic [dis_pkg::ID_W-1:0]          rd_data,
    output logic                              wr_en,
    output logic [$clog2(DEPTH):0]            wr_addr,
    output logic [dis_pkg::ID_W-1:0]          wr_data,
    output logic                              grp,
    output logic [$clog2(DEPTH)-1:0]          lk_idx,
    input  logic                              lk_valid,
    output dis_pkg::res_ctl_t                 res,
    output logic [$clog2(DEPTH)-1:0]          res_slot
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                     state_reg,      state_next;
    logic [dis_pkg::ID_W-1:0] id_reg,         id_next;
    logic                     grp_reg,        grp_next;
    logic [IDX_W-1:0]         iss_idx_reg,    iss_idx_next;
    logic                     iss_run_reg,    iss_run_next;
    logic                     cmp_vld_reg,    cmp_vld_next;
    logic [IDX_W-1:0]         cmp_idx_reg,    cmp_idx_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg,   free_idx_next;

    logic hit;
    logic free_hit;
    logic last_cmp;

    assign hit      = cmp_vld_reg && lk_valid && (rd_data == id_reg);
    assign free_hit = cmp_vld_reg && !lk_valid;
    assign last_cmp = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);

    always_comb
    begin
        state_next      = state_reg;
        id_next         = id_reg;
        grp_next        = grp_reg;
        iss_idx_next    = iss_idx_reg;
        iss_run_next    = iss_run_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        res             = '0;
        res_slot        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next      = S_SCAN;
                    id_next         = item_id;
                    grp_next        = group;
                    iss_idx_next    = '0;
                    iss_run_next    = 1'b1;
                    free_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (iss_run_reg)
                begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_idx_reg;
                    if (iss_idx_reg == LAST_IDX)
                    begin
                        iss_run_next = 1'b0;
                    end
                    else
                    begin
                        iss_idx_next = iss_idx_reg + IDX_W'(1);
                    end
                end
                if (free_hit && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                priority if (hit)
                begin
                    res.done     = 1'b1;
                    res.status   = dis_pkg::ST_PRESENT;
                    res_slot     = cmp_idx_reg;
                    state_next   = S_IDLE;
                    iss_run_next = 1'b0;
                    cmp_vld_next = 1'b0;
                end
                else if (last_cmp)
                begin
                    res.done     = 1'b1;
                    state_next   = S_IDLE;
                    iss_run_next = 1'b0;
                    cmp_vld_next = 1'b0;
                    if (free_found_reg || free_hit)
                    begin
                        res.insert = 1'b1;
                        res.status = dis_pkg::ST_INSERTED;
                        res_slot   = free_found_reg ? free_idx_reg : cmp_idx_reg;
                        wr_en      = 1'b1;
                    end
                    else
                    begin
                        res.status = dis_pkg::ST_FULL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_run_reg    <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_run_reg    <= iss_run_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        grp_reg      <= grp_next;
        iss_idx_reg  <= iss_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign rd_addr = {grp_reg, iss_idx_reg};
    assign wr_addr = {grp_reg, res_slot};
    assign wr_data = id_reg;
    assign grp     = grp_reg;
    assign lk_idx  = cmp_idx_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |=> !busy)
        else $error("scan still busy after result");

    a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> $past(rd_en))
        else $error("compare without a read in the previous cycle");

    a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> res.done && res.status == dis_pkg::ST_INSERTED)
        else $error("ram write outside an insert");

endmodule

FILE: hdl/dedup_id_set_insert.sv
// top level of the deduplicating two-group id set with first-free-slot insert
// depends on dis_pkg, dis_ram, dis_valid and dis_scan
//
// usage: a transaction is taken at a rising edge with start high and busy low;
// item_id and group are sampled there. group 1 picks the healthy set, 0 the
// unhealthy set. busy stays high while the set is scanned.
// one result per transaction: strobe is high for exactly one cycle with status,
// slot and group_count; the receiver cannot hold it off.
// the scan reads one id per cycle from the id ram (one read port, registered
// read data), compares it with the item and stops at the first match; a new id
// or a full table ends the scan after the last slot is compared. the result is
// registered onto strobe. busy is low in the strobe cycle, so the next start is
// taken at the edge that ends it; no new item is taken while a scan runs.
// status: inserted, already present, or table full (slot 0, item dropped).
// group_count is the entry count of the chosen group after the item.
// reset clears the entry counts of both groups; a slot is valid below its group's
// count, so the id ram is not cleared and no clearing pass is needed.

module dedup_id_set_insert #(
    parameter int TABLE_DEPTH = dis_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dis_pkg::ID_W-1:0]       item_id,
    input  logic                           group,
    output logic                           strobe,
    output logic [dis_pkg::STATUS_W-1:0]   status,
    output logic [dis_pkg::SLOT_W-1:0]     slot,
    output logic [dis_pkg::COUNT_W-1:0]    group_count
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_DPTH = 2 * (1 << IDX_W);

    logic                      rd_en;
    logic [IDX_W:0]            rd_addr;
    logic [dis_pkg::ID_W-1:0]  rd_data;
    logic                      wr_en;
    logic [IDX_W:0]            wr_addr;
    logic [dis_pkg::ID_W-1:0]  wr_data;
    logic                      grp;
    logic [IDX_W-1:0]          lk_idx;
    logic                      lk_valid;
    dis_pkg::res_ctl_t         res;
    logic [IDX_W-1:0]          res_slot;
    logic [CNT_W-1:0]          cnt;

    logic [CNT_W-1:0]                  cnt_after;
    logic [IDX_W+dis_pkg::SLOT_W-1:0]  slot_ext;
    logic [CNT_W+dis_pkg::COUNT_W-1:0] cnt_ext;

    logic                          strobe_reg;
    logic [dis_pkg::STATUS_W-1:0]  status_reg;
    logic [dis_pkg::SLOT_W-1:0]    slot_reg,  slot_next;
    logic [dis_pkg::COUNT_W-1:0]   count_reg, count_next;

    dis_ram #(
        .WIDTH (dis_pkg::ID_W),
        .DEPTH (RAM_DPTH)
    ) u_ids (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dis_valid #(
        .DEPTH (TABLE_DEPTH)
    ) u_valid (
        .clk      (clk),
        .rst_n    (rst_n),
        .lk_grp   (grp),
        .lk_idx   (lk_idx),
        .lk_valid (lk_valid),
        .set_en   (res.insert),
        .set_grp  (grp),
        .set_idx  (res_slot),
        .cnt_grp  (grp),
        .cnt      (cnt)
    );

    dis_scan #(
        .DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item_id  (item_id),
        .group    (group),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .grp      (grp),
        .lk_idx   (lk_idx),
        .lk_valid (lk_valid),
        .res      (res),
        .res_slot (res_slot)
    );

    assign cnt_after  = cnt + {{(CNT_W-1){1'b0}}, res.insert};
    assign slot_ext   = {{dis_pkg::SLOT_W{1'b0}}, res_slot};
    assign cnt_ext    = {{dis_pkg::COUNT_W{1'b0}}, cnt_after};
    assign slot_next  = slot_ext[dis_pkg::SLOT_W-1:0];
    assign count_next = cnt_ext[dis_pkg::COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= res.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            status_reg <= res.status;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
        end
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign group_count = count_reg;

    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without a transaction in flight");

    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == dis_pkg::ST_FULL |-> slot == '0)
        else $error("table full result with nonzero slot");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("two results back to back");

endmodule
